>>> sv/tpb_pkg.sv
// ============================================================================
// tpb_pkg: shared types and constants of the threshold promote page buffer
// Field widths, register indexes, reset values and the cell control group.
// ============================================================================
package tpb_pkg;

   // Fixed widths of the transaction fields.
   localparam int PAGE_TAG_W = 32;
   localparam int COUNT_W    = 16;
   localparam int POS_W      = 4;
   localparam int OCC_W      = 5;
   localparam int THRESH_W   = 16;
   localparam int CAP_W      = 5;

   // Configuration port layout.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COUNT_THRESHOLD = 2'd0,
      CSR_CAPACITY        = 2'd1
   } csr_index_type;

   localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd2;
   localparam logic [CAP_W-1:0]    CAP_RESET    = 5'd16;

   // Control group broadcast from the sequencer to every entry cell.
   typedef struct packed {
      logic cmp_en;    // register the tag compare result
      logic shift_en;  // cells at or below the limit take their neighbor's entry
      logic count_wr;  // the matching cell takes the new count in place
   } cell_ctl_type;

endpackage

>>> sv/tpb_cell.sv
// ============================================================================
// tpb_cell: one entry cell of the page buffer chain
// Holds one tag and its count, compares against the request key and takes
// its front neighbor's entry when the chain shifts toward the back.
// ============================================================================
module tpb_cell
   import tpb_pkg::*;
#(
   parameter int INDEX       = 0,
   parameter int MAX_ENTRIES = 16,
   parameter int TAG_BITS    = 32,
   parameter int COUNT_BITS  = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cell_ctl_type                         ctl,
   input  logic [TAG_BITS-1:0]                  key,
   input  logic [$clog2(MAX_ENTRIES)-1:0]       upto,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]     occupancy,
   input  logic [COUNT_BITS-1:0]                new_count,
   input  logic [TAG_BITS-1:0]                  prev_tag,
   input  logic [COUNT_BITS-1:0]                prev_count,
   output logic [TAG_BITS-1:0]                  tag,
   output logic [COUNT_BITS-1:0]                count,
   output logic                                 hit_sel,
   output logic                                 tail_sel
);

   localparam int IDXW = $clog2(MAX_ENTRIES);
   localparam int OCCW = $clog2(MAX_ENTRIES + 1);
   localparam logic [IDXW-1:0] MY_POS  = IDXW'(INDEX);
   localparam logic [OCCW-1:0] MY_OCC  = OCCW'(INDEX);
   localparam logic [OCCW-1:0] MY_NEXT = OCCW'(INDEX + 1);

   logic [TAG_BITS-1:0]   tag_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  hit_ff;
   logic                  valid;

   // The cell holds a live entry when its position is below the fill count.
   assign valid = MY_OCC < occupancy;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (ctl.cmp_en) begin
         hit_ff <= valid && (tag_ff == key);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift_en && (MY_POS <= upto)) begin
         tag_ff   <= prev_tag;
         count_ff <= prev_count;
      end else if (ctl.count_wr && hit_ff) begin
         count_ff <= new_count;
      end
   end

   assign tag      = tag_ff;
   assign count    = count_ff;
   assign hit_sel  = hit_ff;
   assign tail_sel = valid && (occupancy == MY_NEXT);

endmodule

>>> sv/threshold_promote_page_buffer_unit.sv
// ============================================================================
// threshold_promote_page_buffer_unit: ordered page buffer with counted
// move-to-front
// Chain of entry cells with a two-step sequencer: parallel compare, then a
// one-step update that shifts the chain toward the back or counts in place.
// ============================================================================
// A request is accepted on a clock edge where start is high and busy is low.
// Each request has a compare step and an update step: in the first, every
// cell compares its tag with the request key in parallel and registers the
// outcome; in the second, the cell outcomes are gathered, the count is bumped
// and tested against the threshold, and either the hit cell takes the new count
// in place or the chain moves back by one position up to the limit. The
// result is driven on the rsp_ ports for exactly one cycle, flagged by
// rsp_valid, in the cycle after the update step. Busy is high only during the
// compare step, so a new request may be issued while the previous one is
// updating. The receiver cannot stall the result strobe, so it must take each
// result in the cycle it is shown. There is no clearing pass after reset:
// entries are tracked by a fill count, and entry contents are never read
// beyond it. Configuration writes are accepted in any cycle (csr_ready is
// always high) and must only be issued while no request is in flight.
// ============================================================================
module threshold_promote_page_buffer_unit
   import tpb_pkg::*;
#(
   parameter int MAX_ENTRIES = 16,
   parameter int TAG_BITS    = 32,
   parameter int COUNT_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   start,
   output logic                   busy,
   input  logic [PAGE_TAG_W-1:0]  req_page_tag,
   // result channel
   output logic                   rsp_valid,
   output logic                   rsp_hit,
   output logic [POS_W-1:0]       rsp_hit_position,
   output logic                   rsp_promoted,
   output logic [COUNT_W-1:0]     rsp_entry_count,
   output logic                   rsp_evicted,
   output logic [PAGE_TAG_W-1:0]  rsp_evicted_tag,
   output logic [COUNT_W-1:0]     rsp_evicted_count,
   output logic [OCC_W-1:0]       rsp_occupancy,
   // configuration channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDXW = $clog2(MAX_ENTRIES);
   localparam int OCCW = $clog2(MAX_ENTRIES + 1);
   // Width that holds both the fill count and the capacity register.
   localparam int EW   = (OCCW > CAP_W) ? OCCW : CAP_W;
   // Width that holds both the entry count and the threshold register.
   localparam int CMPW = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;
   localparam logic [EW-1:0] MAX_CAP = EW'(MAX_ENTRIES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD
   } state_type;

   state_type             state_ff, state_in;
   logic [TAG_BITS-1:0]   key_ff;
   logic [OCCW-1:0]       occ_ff, occ_in;
   logic [THRESH_W-1:0]   threshold_ff;
   logic [CAP_W-1:0]      capacity_ff;

   logic                  accept;
   logic                  upd;
   cell_ctl_type          ctl;

   // Per-cell views; each element is tied to one cell only.
   logic [TAG_BITS-1:0]   cell_tag   [MAX_ENTRIES];
   logic [COUNT_BITS-1:0] cell_count [MAX_ENTRIES];
   logic                  cell_hit   [MAX_ENTRIES];
   logic                  cell_tail  [MAX_ENTRIES];

   // Gathered cell outcomes.
   logic                  hit_any;
   logic [IDXW-1:0]       hit_pos;
   logic [COUNT_BITS-1:0] hit_cnt;
   logic [TAG_BITS-1:0]   tail_tag;
   logic [COUNT_BITS-1:0] tail_cnt;

   logic [COUNT_BITS-1:0] cnt_inc;
   logic [COUNT_BITS-1:0] new_count;
   logic [EW-1:0]         ecap;
   logic                  promote;
   logic                  evict;
   logic [OCCW-1:0]       occ_kept;
   logic [IDXW-1:0]       upto;

   assign accept    = start && !busy;
   assign busy      = (state_ff == ST_CMP);
   assign upd       = (state_ff == ST_UPD);
   assign csr_ready = 1'b1;

   // Request key; tags are stored at their internal width.
   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff <= TAG_BITS'(req_page_tag);
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESH_RESET;
         capacity_ff  <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COUNT_THRESHOLD: threshold_ff <= csr_data;
            CSR_CAPACITY:        capacity_ff  <= csr_data[CAP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Collect the outcome of the compare step. Stored tags are unique, so at
   // most one cell flags a hit and a plain OR merge picks out its entry.
   always_comb begin
      hit_any  = 1'b0;
      hit_pos  = '0;
      hit_cnt  = '0;
      tail_tag = '0;
      tail_cnt = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         hit_any = hit_any | cell_hit[i];
         if (cell_hit[i]) begin
            hit_pos = hit_pos | IDXW'(i);
            hit_cnt = hit_cnt | cell_count[i];
         end
         if (cell_tail[i]) begin
            tail_tag = tail_tag | cell_tag[i];
            tail_cnt = tail_cnt | cell_count[i];
         end
      end
   end

   // Update decision. A zero capacity acts as one, and anything above the
   // number of cells acts as the number of cells.
   always_comb begin
      if (capacity_ff == '0) begin
         ecap = EW'(1);
      end else if (EW'(capacity_ff) > MAX_CAP) begin
         ecap = MAX_CAP;
      end else begin
         ecap = EW'(capacity_ff);
      end

      cnt_inc   = (hit_cnt == '1) ? hit_cnt : hit_cnt + 1'b1;
      promote   = hit_any && (hit_pos != '0) && (CMPW'(cnt_inc) > CMPW'(threshold_ff));
      // When the capacity was lowered below the fill count, a miss still
      // drops only the tail, so occupancy never grows past its old value.
      evict     = !hit_any && (EW'(occ_ff) >= ecap);
      occ_kept  = evict ? occ_ff - 1'b1 : occ_ff;
      upto      = hit_any ? hit_pos : IDXW'(occ_kept);
      new_count = hit_any ? cnt_inc : COUNT_BITS'(1);

      ctl.cmp_en   = (state_ff == ST_CMP);
      ctl.shift_en = upd && (promote || !hit_any);
      ctl.count_wr = upd && hit_any && !promote;

      occ_in = (upd && !hit_any) ? occ_kept + 1'b1 : occ_ff;
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = start ? ST_CMP : ST_IDLE;
         ST_CMP:  state_in = ST_UPD;
         ST_UPD:  state_in = start ? ST_CMP : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer state, fill count and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         occ_ff    <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         rsp_valid <= upd;
      end
      if (upd) begin
         rsp_hit           <= hit_any;
         rsp_hit_position  <= POS_W'(hit_pos);
         rsp_promoted      <= promote;
         rsp_entry_count   <= COUNT_W'(new_count);
         rsp_evicted       <= evict;
         rsp_evicted_tag   <= evict ? PAGE_TAG_W'(tail_tag) : '0;
         rsp_evicted_count <= evict ? COUNT_W'(tail_cnt) : '0;
         rsp_occupancy     <= OCC_W'(occ_in);
      end
   end

   // The chain of entry cells. Cell 0 takes the request key and its new
   // count as its front neighbor, so a shift puts the request's entry at the front.
   for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      logic [TAG_BITS-1:0]   prev_tag;
      logic [COUNT_BITS-1:0] prev_count;

      if (g == 0) begin : g_front
         assign prev_tag   = key_ff;
         assign prev_count = new_count;
      end else begin : g_inner
         assign prev_tag   = cell_tag[g-1];
         assign prev_count = cell_count[g-1];
      end

      tpb_cell #(
         .INDEX       (g),
         .MAX_ENTRIES (MAX_ENTRIES),
         .TAG_BITS    (TAG_BITS),
         .COUNT_BITS  (COUNT_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key_ff),
         .upto       (upto),
         .occupancy  (occ_ff),
         .new_count  (new_count),
         .prev_tag   (prev_tag),
         .prev_count (prev_count),
         .tag        (cell_tag[g]),
         .count      (cell_count[g]),
         .hit_sel    (cell_hit[g]),
         .tail_sel   (cell_tail[g])
      );
   end

endmodule

>>> sv/tpb_checker.sv
// ============================================================================
// tpb_checker: port-level checks of the threshold promote page buffer
// Watches request and result transactions on the top level's ports.
// ============================================================================
module tpb_checker
   import tpb_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_hit,
   input logic               rsp_promoted,
   input logic [COUNT_W-1:0] rsp_entry_count,
   input logic               rsp_evicted,
   input logic [OCC_W-1:0]   rsp_occupancy
);

   // Every accepted request yields its result after its compare and update steps.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted request produced no result");

   // A request keeps the unit busy for its compare step.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("unit not busy after accepting a request");

   // Results never come in consecutive cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A miss inserts a fresh entry, never promotes, and leaves the buffer
   // non-empty; an eviction only happens on a miss.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_entry_count == COUNT_W'(1)) && !rsp_promoted
                                  && (rsp_occupancy != '0))
      else $error("miss result inconsistent");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_evicted) |-> !rsp_hit)
      else $error("eviction reported on a hit");

endmodule

bind threshold_promote_page_buffer_unit tpb_checker u_tpb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_hit         (rsp_hit),
   .rsp_promoted    (rsp_promoted),
   .rsp_entry_count (rsp_entry_count),
   .rsp_evicted     (rsp_evicted),
   .rsp_occupancy   (rsp_occupancy)
);

>>> tb/threshold_promote_page_buffer_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// threshold_promote_page_buffer_unit_test: self-checking bench for the page
// buffer
// Drives page requests and register writes, predicts every result with a
// behavioral copy of the ordered buffer and compares it field by field.
// ============================================================================
module threshold_promote_page_buffer_unit_test;
   import tpb_pkg::*;

   // The block runs with its default sizes: sixteen entries, full-width
   // tags and sixteen-bit counts.
   localparam int DEPTH          = 16;
   localparam int ITEMS_PER_STEP = 150;
   localparam int RANDOM_STEPS   = 12;
   localparam int QUIET_STEPS    = 2;      // last steps run without sender gaps
   localparam int POOL_MAX       = 24;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 10;
   localparam int WATCHDOG_LIMIT = 1000;

   // One result transaction, in the order of the rsp_ ports.
   typedef struct packed {
      logic                  hit;
      logic [POS_W-1:0]      hit_position;
      logic                  promoted;
      logic [COUNT_W-1:0]    entry_count;
      logic                  evicted;
      logic [PAGE_TAG_W-1:0] evicted_tag;
      logic [COUNT_W-1:0]    evicted_count;
      logic [OCC_W-1:0]      occupancy;
   } page_result_t;

   typedef enum logic [1:0] {
      ROW_REQ,
      ROW_CSR
   } row_kind_t;

   // One line of the directed plan. A request row either carries the result
   // that must come back (typed) or leaves it to the predictor.
   typedef struct packed {
      row_kind_t     kind;
      csr_index_type csr_reg;
      logic [31:0]   value;
      logic          typed;
      page_result_t  want;
   } plan_row_t;

   localparam page_result_t UNTYPED = '0;
   localparam int PLAN_ROWS = 30;

   // Directed plan. The typed rows can be followed by hand from reset:
   // first fill, a hit on the front that stays put, a hit that only reaches
   // the threshold, a promotion, capacity lowered under occupancy so that each
   // miss only trades the tail, capacity zero acting as one, capacity above
   // the buffer size acting as the buffer size, and a hit on the last
   // position of a full buffer.
   localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h0000_0000, 1'b1,
        '{1'b0, 4'd0, 1'b0, 16'd1, 1'b0, 32'h0, 16'd0, 5'd1}},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'hFFFF_FFFF, 1'b1,
        '{1'b0, 4'd0, 1'b0, 16'd1, 1'b0, 32'h0, 16'd0, 5'd2}},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'hFFFF_FFFF, 1'b1,
        '{1'b1, 4'd0, 1'b0, 16'd2, 1'b0, 32'h0, 16'd0, 5'd2}},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h0000_0000, 1'b1,
        '{1'b1, 4'd1, 1'b0, 16'd2, 1'b0, 32'h0, 16'd0, 5'd2}},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h0000_0000, 1'b1,
        '{1'b1, 4'd1, 1'b1, 16'd3, 1'b0, 32'h0, 16'd0, 5'd2}},
      '{ROW_CSR, CSR_CAPACITY, 32'd1, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h1234_5678, 1'b1,
        '{1'b0, 4'd0, 1'b0, 16'd1, 1'b1, 32'hFFFF_FFFF, 16'd2, 5'd2}},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'hA5A5_A5A5, 1'b1,
        '{1'b0, 4'd0, 1'b0, 16'd1, 1'b1, 32'h0000_0000, 16'd3, 5'd2}},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h5A5A_5A5A, 1'b1,
        '{1'b0, 4'd0, 1'b0, 16'd1, 1'b1, 32'h1234_5678, 16'd1, 5'd2}},
      '{ROW_CSR, CSR_COUNT_THRESHOLD, 32'd0, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'hA5A5_A5A5, 1'b1,
        '{1'b1, 4'd1, 1'b1, 16'd2, 1'b0, 32'h0, 16'd0, 5'd2}},
      '{ROW_CSR, CSR_CAPACITY, 32'd0, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h0000_0001, 1'b1,
        '{1'b0, 4'd0, 1'b0, 16'd1, 1'b1, 32'h5A5A_5A5A, 16'd1, 5'd2}},
      '{ROW_CSR, CSR_CAPACITY, 32'd31, 1'b0, UNTYPED},
      '{ROW_CSR, CSR_COUNT_THRESHOLD, 32'h0000_FFFF, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h8000_0000, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h4000_0000, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h0001_0000, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h0000_8000, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'hDEAD_BEEF, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'hCAFE_F00D, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h7FFF_FFFF, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'hFFFF_FFFE, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h0000_0003, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h1111_1111, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h2222_2222, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h3333_3333, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h4444_4444, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'h5555_5555, 1'b0, UNTYPED},
      '{ROW_REQ, CSR_COUNT_THRESHOLD, 32'hA5A5_A5A5, 1'b1,
        '{1'b1, 4'd15, 1'b0, 16'd3, 1'b0, 32'h0, 16'd0, 5'd16}}
   };

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [PAGE_TAG_W-1:0] req_page_tag;
   logic                  rsp_valid;
   logic                  rsp_hit;
   logic [POS_W-1:0]      rsp_hit_position;
   logic                  rsp_promoted;
   logic [COUNT_W-1:0]    rsp_entry_count;
   logic                  rsp_evicted;
   logic [PAGE_TAG_W-1:0] rsp_evicted_tag;
   logic [COUNT_W-1:0]    rsp_evicted_count;
   logic [OCC_W-1:0]      rsp_occupancy;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Behavioral copy of the buffer: entries in order with the front at
   // index zero, plus the two register values.
   logic [PAGE_TAG_W-1:0] held_tags [DEPTH];
   logic [COUNT_W-1:0]    held_counts [DEPTH];
   int                    fill_level;
   logic [THRESH_W-1:0]   promote_threshold;
   logic [CAP_W-1:0]      capacity_setting;

   // Results predicted for accepted requests, oldest first.
   page_result_t          pending_results [$];
   int                    mismatches;
   int                    quiet_cycles;

   threshold_promote_page_buffer_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_page_tag      (req_page_tag),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_hit_position  (rsp_hit_position),
      .rsp_promoted      (rsp_promoted),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_evicted       (rsp_evicted),
      .rsp_evicted_tag   (rsp_evicted_tag),
      .rsp_evicted_count (rsp_evicted_count),
      .rsp_occupancy     (rsp_occupancy),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Moves the first `upto` entries back by one and puts the given entry at
   // the front. Used both for a promotion and for inserting a new page.
   function automatic void shift_to_front(int upto, logic [PAGE_TAG_W-1:0] tag,
                                          logic [COUNT_W-1:0] count);
      for (int i = upto; i > 0; i--) begin
         held_tags[i]   = held_tags[i-1];
         held_counts[i] = held_counts[i-1];
      end
      held_tags[0]   = tag;
      held_counts[0] = count;
   endfunction

   // Applies one page request to the copy of the buffer and returns the
   // result the block has to produce for it.
   function automatic page_result_t predict_access(logic [PAGE_TAG_W-1:0] tag);
      page_result_t       r;
      int                 pos;
      int                 room;
      logic [COUNT_W-1:0] count;
      r             = '0;
      r.entry_count = 16'd1;
      pos           = -1;
      for (int i = 0; i < fill_level; i++) begin
         if (pos < 0 && held_tags[i] == tag) pos = i;
      end
      if (pos >= 0) begin
         r.hit          = 1'b1;
         r.hit_position = pos[POS_W-1:0];
         count          = held_counts[pos];
         // The count sticks at its top value instead of wrapping.
         if (count != {COUNT_W{1'b1}}) count = count + 16'd1;
         held_counts[pos] = count;
         r.entry_count    = count;
         // A hit on the front entry never counts as a promotion.
         if (count > promote_threshold && pos != 0) begin
            shift_to_front(pos, tag, count);
            r.promoted = 1'b1;
         end
      end else begin
         // Zero behaves as one and anything above the buffer size as the
         // buffer size. A capacity lowered under the fill level only trades
         // the tail on each miss, so occupancy never grows past it.
         room = int'(capacity_setting);
         if (room == 0) room = 1;
         if (room > DEPTH) room = DEPTH;
         if (fill_level >= room && fill_level > 0) begin
            r.evicted       = 1'b1;
            r.evicted_tag   = held_tags[fill_level-1];
            r.evicted_count = held_counts[fill_level-1];
            fill_level--;
         end
         shift_to_front(fill_level, tag, 16'd1);
         fill_level++;
      end
      r.occupancy = fill_level[OCC_W-1:0];
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want,
                                       logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // Presents one page request and holds it until the block takes it. The
   // request is accepted at the rising edge where start is high and busy is
   // low, so busy is looked at just after each edge, before the block's own
   // updates land. The prediction is made at that same edge; the result
   // comes only after the compare and update steps, so it is queued in time.
   task automatic issue_request(logic [PAGE_TAG_W-1:0] tag, logic typed,
                                page_result_t want);
      page_result_t predicted;
      @(negedge clock);
      start        <= 1'b1;
      req_page_tag <= tag;
      do @(posedge clock); while (busy);
      predicted = predict_access(tag);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // A gap on the request side: start is driven low.
   task automatic pause_sender(int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // Brings the block to rest before a register write. Every request has
   // exactly one result, so an empty queue means nothing is in flight; the
   // extra cycles only give the last strobe time to clear.
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_COUNT_THRESHOLD: promote_threshold = data;
         CSR_CAPACITY:        capacity_setting  = data[CAP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Result checker. The receiver cannot hold results off, so every strobe
   // is a transaction and must match the oldest outstanding prediction.
   always @(posedge clock) begin : result_check
      page_result_t want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with no request outstanding");
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            check_field("hit", 32'(want.hit), 32'(rsp_hit));
            check_field("hit_position", 32'(want.hit_position),
                        32'(rsp_hit_position));
            check_field("promoted", 32'(want.promoted), 32'(rsp_promoted));
            check_field("entry_count", 32'(want.entry_count),
                        32'(rsp_entry_count));
            check_field("evicted", 32'(want.evicted), 32'(rsp_evicted));
            check_field("evicted_tag", want.evicted_tag, rsp_evicted_tag);
            check_field("evicted_count", 32'(want.evicted_count),
                        32'(rsp_evicted_count));
            check_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
         end
      end
   end

   // Watchdog. Any accepted transaction on any of the three channels resets
   // the count; a long stretch with none means the block has hung.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("threshold_promote_page_buffer_unit: mismatch");
            $finish;
         end
      end
   end

   initial begin : stimulus
      logic [PAGE_TAG_W-1:0] tag_pool [POOL_MAX];
      logic [PAGE_TAG_W-1:0] tag;
      logic [THRESH_W-1:0]   thr;
      logic [CAP_W-1:0]      cap;
      int                    room;
      int                    pool_size;
      plan_row_t             row;

      reset             = 1'b1;
      start             = 1'b0;
      req_page_tag      = '0;
      csr_valid         = 1'b0;
      csr_index         = CSR_COUNT_THRESHOLD;
      csr_data          = '0;
      mismatches        = 0;
      quiet_cycles      = 0;
      fill_level        = 0;
      promote_threshold = THRESH_RESET;
      capacity_setting  = CAP_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         held_tags[i]   = '0;
         held_counts[i] = '0;
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: walk the plan. Register rows wait for the block to
      // go quiet first.
      for (int r = 0; r < PLAN_ROWS; r++) begin
         row = DIRECTED_PLAN[r];
         if (row.kind == ROW_CSR) begin
            drain_results();
            write_csr(row.csr_reg, row.value[CSR_DATA_W-1:0]);
         end else begin
            issue_request(row.value, row.typed, row.want);
         end
      end

      // Random part. Each step picks a register setting, then requests pages
      // mostly from a small pool sized around the capacity so that hits,
      // promotions and evictions all happen often; the rest are fresh tags.
      // The first steps pin the extreme settings.
      for (int s = 0; s < RANDOM_STEPS; s++) begin
         drain_results();
         case (s)
            0: begin
               thr = 16'd0;
               cap = 5'd16;
            end
            1: begin
               thr = 16'hFFFF;
               cap = 5'd1;
            end
            2: begin
               thr = 16'd1;
               cap = 5'd2;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       thr = 16'($urandom_range(0, 4));
                  1:       thr = 16'hFFFF;
                  2:       thr = 16'($urandom());
                  default: thr = 16'($urandom_range(0, 12));
               endcase
               if ($urandom_range(0, 3) == 0) cap = 5'($urandom_range(0, 31));
               else cap = 5'($urandom_range(1, 16));
            end
         endcase
         write_csr(CSR_COUNT_THRESHOLD, thr);
         write_csr(CSR_CAPACITY, {{(CSR_DATA_W-CAP_W){1'b0}}, cap});

         room = int'(cap);
         if (room == 0) room = 1;
         if (room > DEPTH) room = DEPTH;
         pool_size = $urandom_range(2, room + 6);
         if (pool_size > POOL_MAX) pool_size = POOL_MAX;
         for (int k = 0; k < POOL_MAX; k++) tag_pool[k] = $urandom();

         // The last steps run with no sender gaps at all, back to back.
         for (int n = 0; n < ITEMS_PER_STEP; n++) begin
            if ($urandom_range(0, 99) < 85) tag = tag_pool[$urandom_range(0, pool_size - 1)];
            else tag = $urandom();
            if (s < RANDOM_STEPS - QUIET_STEPS && $urandom_range(0, 7) == 0)
               pause_sender($urandom_range(1, 15));
            issue_request(tag, 1'b0, UNTYPED);
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("threshold_promote_page_buffer_unit: match");
      end else begin
         $display("threshold_promote_page_buffer_unit: mismatch");
      end
      $finish;
   end

endmodule
